### rtl/core/ceb_pkg.sv
// Package for the coincidence event builder: counter sizing, field widths,
// reset values and the count clamp used on result fields.
// No dependencies.
package ceb_pkg;

	// Per-side hit counter width; counters saturate at all ones
	localparam int unsigned COUNT_WIDTH = 8;
	localparam int unsigned NUM_SIDES   = 8;
	localparam int unsigned SIDE_W      = $clog2(NUM_SIDES);

	localparam int unsigned EVENT_W  = 32;
	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned ENERGY_W = 32;
	localparam int unsigned CLASS_W  = 2;
	localparam int unsigned FIELD_W  = 8;

	// Packed stream widths, rounded up to whole bytes
	localparam int unsigned IN_BITS   = EVENT_W + CHAN_W + ENERGY_W + CLASS_W;
	localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS  = 4 * FIELD_W + CLASS_W;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = ENERGY_W'(100000);

	localparam logic BOX_A = 1'b0;
	localparam logic BOX_B = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Clamp a counter to the width of a result field
	function automatic logic [FIELD_W-1:0] clamp_count(input count_t cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		return (wide > 32'((1 << FIELD_W) - 1)) ? {FIELD_W{1'b1}} : wide[FIELD_W-1:0];
	endfunction

endpackage

### rtl/core/coincidence_event_builder_top.sv
// Coincidence event builder: per-side hit counting and box coincidence check.
// Depends on ceb_pkg for widths, reset values and the count clamp.
//
// channel  | dir | payload
// ---------+-----+---------------------------------------------------------------
// s_*      | in  | tdata: event_id, channel, energy, particle_class; tlast: flush
// m_*      | out | tdata: first_front/back, second_front/back, event_particle;
//          |     | tuser: box
// cfg_*    | in  | data: energy_threshold
//
// Each item passes an input register (_s1) and combinational logic into the
// result register; m_tvalid is registered from an item that closes a box hit.
// One item is taken per cycle while m_tready is high; the result register
// stalls the input register, which in turn drops s_tready.
// Reset clears the open-event state, all eight side counters and the
// threshold (to 100000 eV); there is no clearing pass.
module coincidence_event_builder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// event_id[31:0], channel[35:32], energy[67:36], particle_class[69:68]
	input  logic [ceb_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tlast,   // flush
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// first_front[7:0], first_back[15:8], second_front[23:16],
	// second_back[31:24], event_particle[33:32]
	output logic [ceb_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tuser,   // box
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [ceb_pkg::ENERGY_W-1:0]       cfg_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready
);

	localparam int unsigned CW = ceb_pkg::COUNT_WIDTH;
	localparam int unsigned NS = ceb_pkg::NUM_SIDES;

	// Configuration
	logic [ceb_pkg::ENERGY_W-1:0] threshold_q;

	// Input register
	logic                         valid_s1;
	logic                         flush_s1;
	logic [ceb_pkg::EVENT_W-1:0]  event_id_s1;
	logic [ceb_pkg::CHAN_W-1:0]   channel_s1;
	logic [ceb_pkg::ENERGY_W-1:0] energy_s1;
	logic [ceb_pkg::CLASS_W-1:0]  class_s1;

	// Event state
	logic                         event_open_q;
	logic [ceb_pkg::EVENT_W-1:0]  open_id_q;
	logic [ceb_pkg::CLASS_W-1:0]  open_class_q;
	ceb_pkg::count_t              counts_q [NS];
	ceb_pkg::count_t              counts_d [NS];

	// Result register
	logic                           res_valid_q;
	logic                           res_box_q;
	logic [ceb_pkg::OUT_DATA_W-1:0] res_data_q;

	logic advance;      // result register can take a new value
	logic fire;         // input register item processed this cycle
	logic close_evt;
	logic counted;
	logic det0, det1, det2, det3;
	logic hit_a, hit_b;
	logic [ceb_pkg::OUT_DATA_W-1:0] res_data_d;

	assign cfg_ready = 1'b1;

	assign advance  = !res_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_data_q;
	assign m_tuser  = res_box_q;

	// An open event closes on flush or on a change of event number
	assign close_evt = event_open_q && (flush_s1 || (event_id_s1 != open_id_q));

	// Only valid channels above the threshold count; a flush never counts
	assign counted = !flush_s1 && (energy_s1 > threshold_q) && !channel_s1[ceb_pkg::CHAN_W-1];

	// A detector is hit when either of its sides counted anything
	assign det0 = (counts_q[0] | counts_q[1]) != '0;
	assign det1 = (counts_q[2] | counts_q[3]) != '0;
	assign det2 = (counts_q[4] | counts_q[5]) != '0;
	assign det3 = (counts_q[6] | counts_q[7]) != '0;
	assign hit_a = det0 && det1;
	assign hit_b = det2 && det3;

	// Pick box A first, box B otherwise; pack into tdata order
	always_comb begin
		res_data_d = '0;
		if (hit_a) begin
			res_data_d[7:0]   = ceb_pkg::clamp_count(counts_q[0]);
			res_data_d[15:8]  = ceb_pkg::clamp_count(counts_q[1]);
			res_data_d[23:16] = ceb_pkg::clamp_count(counts_q[2]);
			res_data_d[31:24] = ceb_pkg::clamp_count(counts_q[3]);
		end else begin
			res_data_d[7:0]   = ceb_pkg::clamp_count(counts_q[4]);
			res_data_d[15:8]  = ceb_pkg::clamp_count(counts_q[5]);
			res_data_d[23:16] = ceb_pkg::clamp_count(counts_q[6]);
			res_data_d[31:24] = ceb_pkg::clamp_count(counts_q[7]);
		end
		res_data_d[33:32] = open_class_q;
	end

	// Next counter values: clear on close, then add this hit with saturation
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			counts_d[i] = close_evt ? '0 : counts_q[i];
			if (counted && (channel_s1[ceb_pkg::SIDE_W-1:0] == ceb_pkg::SIDE_W'(i))) begin
				if (counts_d[i] != {CW{1'b1}}) begin
					counts_d[i] = counts_d[i] + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= ceb_pkg::THRESHOLD_RESET;
			valid_s1     <= 1'b0;
			event_open_q <= 1'b0;
			open_id_q    <= '0;
			open_class_q <= '0;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < NS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				threshold_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				res_valid_q <= fire && close_evt && (hit_a || hit_b);
			end
			if (fire) begin
				if (flush_s1) begin
					event_open_q <= 1'b0;
				end else begin
					event_open_q <= 1'b1;
					// Latch number and class of the first hit of a new event
					if (!event_open_q || close_evt) begin
						open_id_q    <= event_id_s1;
						open_class_q <= class_s1;
					end
				end
				for (int i = 0; i < NS; i++) begin
					counts_q[i] <= counts_d[i];
				end
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			flush_s1    <= s_tlast;
			event_id_s1 <= s_tdata[31:0];
			channel_s1  <= s_tdata[35:32];
			energy_s1   <= s_tdata[67:36];
			class_s1    <= s_tdata[69:68];
		end
		if (fire && close_evt && (hit_a || hit_b)) begin
			res_data_q <= res_data_d;
			res_box_q  <= hit_a ? ceb_pkg::BOX_A : ceb_pkg::BOX_B;
		end
	end

`ifndef SYNTHESIS
	// No counts survive outside an open event
	assert property (@(posedge clk) disable iff (!arst_n)
		!event_open_q |-> (det0 == 1'b0 && det1 == 1'b0 && det2 == 1'b0 && det3 == 1'b0))
		else $error("side counters non-zero with no open event");

	// A processed flush leaves no event open
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && flush_s1) |=> !event_open_q)
		else $error("event still open after flush");

	// A result appears only from an item processed in the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(fire && close_evt))
		else $error("result without a closing event");

	// A reported box really had both detectors hit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[7:0] | m_tdata[15:8]) != 8'h00 &&
			(m_tdata[23:16] | m_tdata[31:24]) != 8'h00))
		else $error("result for a box without coincidence");

	// An empty result register never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> s_tready)
		else $error("input stalled with empty result register");
`endif

endmodule
